/* design/bisulfite_fastq_converter_core_defines.svh */
// Assertion macros shared by the bisulfite FASTQ converter RTL.
// Depends on nothing; the including file supplies clock, reset and expressions.
`ifndef BISULFITE_FASTQ_CONVERTER_CORE_DEFINES_SVH
`define BISULFITE_FASTQ_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bfc_pkg.sv */
// Shared types and constants of the bisulfite FASTQ converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package bfc_pkg;

  localparam int ByteW        = 8;
  localparam int CntW         = 48;
  localparam int LimitW       = 32;
  localparam int CfgDataW     = 32;
  localparam int CfgAddrW     = 4;
  localparam int FifoDepthDef = 4;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

  localparam logic [ByteW-1:0] CharUpC = 8'h43;
  localparam logic [ByteW-1:0] CharLoC = 8'h63;
  localparam logic [ByteW-1:0] CharUpT = 8'h54;
  localparam logic [ByteW-1:0] CharUpG = 8'h47;
  localparam logic [ByteW-1:0] CharLoG = 8'h67;
  localparam logic [ByteW-1:0] CharUpA = 8'h41;
  localparam logic [ByteW-1:0] CharNl  = 8'h0A;

  // Line kinds of a FASTQ record.
  localparam logic [1:0] KindName = 2'd0;
  localparam logic [1:0] KindSeq  = 2'd1;
  localparam logic [1:0] KindPlus = 2'd2;
  localparam logic [1:0] KindQual = 2'd3;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] RegPrimaryIsGa = 2'd0;
  localparam logic [1:0] RegDirectional = 2'd1;
  localparam logic [1:0] RegReadLimit   = 2'd2;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [1:0]       kind;
    logic             rec_end;
    logic [CntW-1:0]  reads;
  } bfc_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bfc_qstat_t;

endpackage

/* design/bfc_front.sv */
// Front end: accepts input bytes, tracks the record line and counts reads.
// Depends on bfc_pkg; feeds classified words into bfc_queue.
module bfc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [bfc_pkg::ByteW-1:0] in_tdata,   // [7:0] in_byte
  input  logic [bfc_pkg::LimitW-1:0] read_limit,
  input  bfc_pkg::bfc_qstat_t       qstat,
  output logic                      push,
  output bfc_pkg::bfc_word_t        push_word,
  output logic                      stopped
);
  import bfc_pkg::*;

  logic [1:0]      phase_r, phase_nxt;
  logic            start_r, start_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            stopped_r, stopped_nxt;
  logic            accept;
  logic            is_nl;
  logic            rec_end;
  logic            limit_hit;

  // Once stopped, bytes are still taken but thrown away.
  assign in_tready = stopped_r || !qstat.full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && !stopped_r;
  assign stopped   = stopped_r;

  assign is_nl   = (in_tdata == CharNl);
  assign rec_end = is_nl && (phase_r == KindQual);

  always_comb begin
    cnt_nxt = cnt_r;
    if (phase_r == KindName && start_r && cnt_r != CntMax) begin
      cnt_nxt = cnt_r + CntW'(1);
    end
  end

  assign limit_hit = rec_end && (read_limit != '0) &&
                     (cnt_nxt >= {{(CntW-LimitW){1'b0}}, read_limit});

  always_comb begin
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    stopped_nxt = stopped_r;
    if (push) begin
      phase_nxt = is_nl ? phase_r + 2'd1 : phase_r;
      start_nxt = is_nl;
      if (limit_hit) begin
        stopped_nxt = 1'b1;
      end
    end
  end

  assign push_word.data    = in_tdata;
  assign push_word.kind    = phase_r;
  assign push_word.rec_end = rec_end;
  assign push_word.reads   = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= KindName;
      start_r   <= 1'b1;
      cnt_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
      stopped_r <= stopped_nxt;
      if (push) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

/* design/bfc_queue.sv */
// Short first-word-fall-through queue between the front and back ends.
// Depends on bfc_pkg for the word and status types.
module bfc_queue #(
  parameter int DEPTH = bfc_pkg::FifoDepthDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bfc_pkg::bfc_word_t  push_word,
  input  logic                pop,
  output bfc_pkg::bfc_word_t  pop_word,
  output bfc_pkg::bfc_qstat_t qstat
);
  import bfc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntQW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0]  PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntQW-1:0] CntFull = CntQW'(DEPTH);

  bfc_word_t        mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntQW-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count_r == CntFull);
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_word    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CntQW'(1);
      2'b01:   count_nxt = count_r - CntQW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* design/bfc_back.sv */
// Back end: applies the C-to-T and G-to-A conversion and holds the result word.
// Depends on bfc_pkg; drains words from bfc_queue.
module bfc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bfc_pkg::bfc_qstat_t      qstat,
  input  bfc_pkg::bfc_word_t       pop_word,
  output logic                     pop,
  input  logic                     primary_is_ga,
  input  logic                     directional_mode,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [63:0]              out_tdata,  // [7:0] primary_byte, [15:8] secondary_byte,
                                               // [63:16] reads_seen
  output logic [2:0]               out_tuser,  // [0] secondary_valid, [2:1] line_kind
  output logic                     out_tlast   // record_end
);
  import bfc_pkg::*;

  logic [ByteW-1:0] ct_byte, ga_byte, prim, sec;
  logic             valid_r;
  logic [ByteW-1:0] prim_r, sec_r;
  logic             sec_valid_r;
  logic [1:0]       kind_r;
  logic             rec_end_r;
  logic [CntW-1:0]  reads_r;

  // The output register refills whenever it is empty or being drained.
  assign pop = !qstat.empty && (!valid_r || out_tready);

  always_comb begin
    ct_byte = pop_word.data;
    ga_byte = pop_word.data;
    if (pop_word.kind == KindSeq) begin
      if (pop_word.data == CharUpC || pop_word.data == CharLoC) begin
        ct_byte = CharUpT;
      end
      if (pop_word.data == CharUpG || pop_word.data == CharLoG) begin
        ga_byte = CharUpA;
      end
    end
    prim = primary_is_ga ? ga_byte : ct_byte;
    sec  = directional_mode ? '0 : (primary_is_ga ? ct_byte : ga_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      prim_r      <= prim;
      sec_r       <= sec;
      sec_valid_r <= !directional_mode;
      kind_r      <= pop_word.kind;
      rec_end_r   <= pop_word.rec_end;
      reads_r     <= pop_word.reads;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {reads_r, sec_r, prim_r};
  assign out_tuser  = {kind_r, sec_valid_r};
  assign out_tlast  = rec_end_r;

endmodule

/* design/bisulfite_fastq_converter_core.sv */
// Bisulfite FASTQ converter: one byte in, one converted word out per cycle, set
// by the front end, while neither side stalls. A taken byte is written into the
// queue and then popped into the output register that drives out_tvalid; the
// queue of FIFO_DEPTH words and the output register absorb back-pressure.
// Reset (rst_n low, synchronous) clears the valid flag, queue pointers, settings,
// line tracking, read count and the stop flag; no clearing pass is needed.
`include "bisulfite_fastq_converter_core_defines.svh"

module bisulfite_fastq_converter_core #(
  parameter int FIFO_DEPTH = bfc_pkg::FifoDepthDef
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bfc_pkg::ByteW-1:0]    in_tdata,   // [7:0] in_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [63:0]                  out_tdata,  // [7:0] primary_byte,
                                                   // [15:8] secondary_byte,
                                                   // [63:16] reads_seen
  output logic [2:0]                   out_tuser,  // [0] secondary_valid, [2:1] line_kind
  output logic                         out_tlast,  // record_end
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [bfc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [bfc_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [bfc_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import bfc_pkg::*;

  logic              primary_is_ga_r;
  logic              directional_r;
  logic [LimitW-1:0] read_limit_r;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  bfc_qstat_t qstat;
  bfc_word_t  push_word;
  bfc_word_t  pop_word;
  logic       push;
  logic       pop;
  logic       stopped;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primary_is_ga_r <= 1'b0;
      directional_r   <= 1'b0;
      read_limit_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegPrimaryIsGa: primary_is_ga_r <= cfg_pwdata[0];
        RegDirectional: directional_r   <= cfg_pwdata[0];
        RegReadLimit:   read_limit_r    <= cfg_pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegPrimaryIsGa: cfg_prdata = {{(CfgDataW-1){1'b0}}, primary_is_ga_r};
      RegDirectional: cfg_prdata = {{(CfgDataW-1){1'b0}}, directional_r};
      RegReadLimit:   cfg_prdata = read_limit_r;
      default:        cfg_prdata = '0;
    endcase
  end

  bfc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .read_limit (read_limit_r),
    .qstat      (qstat),
    .push       (push),
    .push_word  (push_word),
    .stopped    (stopped)
  );

  bfc_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .qstat     (qstat)
  );

  bfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .qstat            (qstat),
    .pop_word         (pop_word),
    .pop              (pop),
    .primary_is_ga    (primary_is_ga_r),
    .directional_mode (directional_r),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .out_tlast        (out_tlast)
  );

  `BFC_ASSERT_NOW(a_no_push_when_full, clk, rst_n, push, !qstat.full, "push into full queue")
  `BFC_ASSERT_NEXT(a_stop_sticks, clk, rst_n, stopped, stopped, "stop flag cleared")
  `BFC_ASSERT_NOW(a_no_push_when_stopped, clk, rst_n, stopped, !push, "word queued after stop")
  `BFC_ASSERT_NOW(a_last_on_quality, clk, rst_n, out_tvalid && out_tlast, out_tuser[2:1] == KindQual, "record end outside quality line")

endmodule
